### hdl/reader_writer_lock_slot_table_assert.svh
// assertion macros for the reader-writer lock slot table checker
`ifndef READER_WRITER_LOCK_SLOT_TABLE_ASSERT_SVH
`define READER_WRITER_LOCK_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define RWL_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rwl assertion failed");

// next-cycle implication
`define RWL_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rwl assertion failed");

`endif

### hdl/rwl_pkg.sv
// shared types, constants and helper functions of the reader-writer lock
`default_nettype none
package rwl_pkg;

   localparam int READER_SLOTS = 8;
   localparam int AGENT_IDS    = 16;
   localparam int TIME_BITS    = 48;

   localparam int TYPE_W  = 3;
   localparam int ID_W    = 4;
   localparam int MASK_W  = 16;
   localparam int LEASE_W = 32;
   localparam int OUT_W   = 4;
   localparam int OUT_MAX = (1 << OUT_W) - 1;
   localparam int CNT_W   = $clog2(READER_SLOTS + 1);

   localparam logic [LEASE_W-1:0] LEASE_RESET = 32'd5000000;

   typedef enum logic [TYPE_W-1:0] {
      OP_ACQ_SH     = 3'd0,
      OP_REL_SH     = 3'd1,
      OP_ACQ_EX     = 3'd2,
      OP_REL_EX     = 3'd3,
      OP_CLEAR_DEAD = 3'd4,
      OP_SWEEP      = 3'd5
   } rwl_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } rwl_state_type;

   typedef struct packed {
      logic [TYPE_W-1:0]    req_type;
      logic [ID_W-1:0]      requester;
      logic [TIME_BITS-1:0] now_us;
      logic [MASK_W-1:0]    alive_mask;
   } rwl_req_type;

   typedef struct packed {
      logic             granted;
      logic [OUT_W-1:0] cleaned;
      logic [OUT_W-1:0] readers_now;
      logic [ID_W-1:0]  writer_now;
   } rwl_rsp_type;

   // broadcast to every cell in the accept cycle
   typedef struct packed {
      logic                 sample;
      logic [ID_W-1:0]      requester;
      logic [TIME_BITS-1:0] now_us;
      logic [MASK_W-1:0]    alive_mask;
      logic [LEASE_W-1:0]   lease;
   } rwl_probe_type;

   // broadcast to every cell in the apply cycle
   typedef struct packed {
      logic                 apply;
      logic                 sweep_exp;
      logic                 sweep_dead;
      logic                 clear_hit;
      logic                 take_free;
      logic                 take_swept;
      logic [ID_W-1:0]      owner;
      logic [TIME_BITS-1:0] stamp;
   } rwl_cmd_type;

   // passed from cell to cell along the row
   typedef struct packed {
      logic             hit_any;
      logic             free_seen;
      logic             swp_seen;
      logic [CNT_W-1:0] cnt_exp;
      logic [CNT_W-1:0] cnt_dead;
   } rwl_chain_type;

   function automatic logic rwl_alive(input logic [ID_W-1:0] id,
                                      input logic [MASK_W-1:0] mask);
      return (id != '0) && (32'(id) < AGENT_IDS) && mask[id];
   endfunction

   function automatic logic rwl_expired(input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] stamp,
                                        input logic [LEASE_W-1:0]   lease);
      logic [TIME_BITS-1:0] age;
      age = now - stamp;
      return age > TIME_BITS'(lease);
   endfunction

   function automatic logic [OUT_W-1:0] rwl_sat(input logic [CNT_W-1:0] v);
      return (32'(v) > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
   endfunction

endpackage
`default_nettype wire

### hdl/rwl_cell.sv
// one reader slot: owner and grant time, per-request flags, row chain logic
`default_nettype none
module rwl_cell import rwl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rwl_probe_type probe,
   input  wire rwl_cmd_type   cmd,
   input  wire rwl_chain_type chain_in,
   output rwl_chain_type      chain_out
);

   logic [ID_W-1:0]      owner_ff, owner_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   logic                 hit_ff, hit_in;
   logic                 free_ff, free_in;
   logic                 swe_ff, swe_in;
   logic                 swd_ff, swd_in;
   logic                 occ, other, dead, take, drop;

   // flags are taken against the slot contents while the request is accepted
   always_comb begin
      occ     = owner_ff != '0;
      other   = occ && (owner_ff != probe.requester);
      dead    = !rwl_alive(owner_ff, probe.alive_mask);
      hit_in  = hit_ff;
      free_in = free_ff;
      swe_in  = swe_ff;
      swd_in  = swd_ff;
      if (probe.sample) begin
         hit_in  = occ && (owner_ff == probe.requester);
         free_in = !occ;
         swd_in  = other && dead;
         swe_in  = other && (dead || rwl_expired(probe.now_us, stamp_ff, probe.lease));
      end
   end

   always_comb begin
      chain_out.hit_any   = chain_in.hit_any || hit_ff;
      chain_out.free_seen = chain_in.free_seen || free_ff;
      chain_out.swp_seen  = chain_in.swp_seen || swe_ff;
      chain_out.cnt_exp   = chain_in.cnt_exp + CNT_W'(swe_ff);
      chain_out.cnt_dead  = chain_in.cnt_dead + CNT_W'(swd_ff);
   end

   // take the lowest free slot, or the lowest swept slot when the row was full; else clear swept or hit slots
   always_comb begin
      take = cmd.apply &&
             ((cmd.take_free && free_ff && !chain_in.free_seen) ||
              (cmd.take_swept && swe_ff && !chain_in.swp_seen));
      drop = cmd.apply &&
             ((cmd.sweep_exp && swe_ff) || (cmd.sweep_dead && swd_ff) ||
              (cmd.clear_hit && hit_ff));
      owner_in = owner_ff;
      stamp_in = stamp_ff;
      if (take) begin
         owner_in = cmd.owner;
         stamp_in = cmd.stamp;
      end else if (drop) begin
         owner_in = '0;
         stamp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= '0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         swe_ff   <= 1'b0;
         swd_ff   <= 1'b0;
      end else begin
         owner_ff <= owner_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
         swe_ff   <= swe_in;
         swd_ff   <= swd_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
   end

endmodule
`default_nettype wire

### hdl/rwl_ctrl.sv
// sequencer, writer register, reader count, lease register and result beat
`default_nettype none
module rwl_ctrl import rwl_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire rwl_req_type         req_data,
   output logic                     rsp_valid,
   output rwl_rsp_type              rsp_data,
   input  wire logic                csr_we,
   input  wire logic [LEASE_W-1:0]  csr_wdata,
   output rwl_probe_type            probe,
   output rwl_cmd_type              cmd,
   input  wire rwl_chain_type       row
);

   rwl_state_type        state_ff, state_in;
   rwl_req_type          req_ff, req_in;
   logic [LEASE_W-1:0]   lease_ff, lease_in;
   logic [ID_W-1:0]      wr_owner_ff, wr_owner_in;
   logic [TIME_BITS-1:0] wr_stamp_ff, wr_stamp_in;
   logic                 wvalid_ff, wvalid_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rwl_rsp_type          rsp_ff, rsp_in;

   logic                 accept, apply;
   logic                 grant, inc, w_clear, w_take, w_other;
   logic [CNT_W-1:0]     cleaned, dec;

   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = start ? ST_APPLY : ST_IDLE;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            apply  = 1'b0;
            accept = start;
         end
         ST_APPLY: begin
            busy   = 1'b1;
            apply  = 1'b1;
            accept = 1'b0;
         end
         default: begin
            busy   = 1'b0;
            apply  = 1'b0;
            accept = 1'b0;
         end
      endcase
   end

   always_comb begin
      req_in    = accept ? req_data : req_ff;
      lease_in  = csr_we ? csr_wdata : lease_ff;
      wvalid_in = wvalid_ff;
      if (accept) begin
         wvalid_in = (wr_owner_ff != '0) && rwl_alive(wr_owner_ff, req_data.alive_mask) &&
                     !rwl_expired(req_data.now_us, wr_stamp_ff, lease_ff);
      end
   end

   always_comb begin
      probe.sample     = accept;
      probe.requester  = req_data.requester;
      probe.now_us     = req_data.now_us;
      probe.alive_mask = req_data.alive_mask;
      probe.lease      = lease_ff;
   end

   // request decision from the writer state and the row summary
   always_comb begin
      grant          = 1'b0;
      inc            = 1'b0;
      w_clear        = 1'b0;
      w_take         = 1'b0;
      cleaned        = '0;
      dec            = '0;
      cmd.apply      = apply;
      cmd.sweep_exp  = 1'b0;
      cmd.sweep_dead = 1'b0;
      cmd.clear_hit  = 1'b0;
      cmd.take_free  = 1'b0;
      cmd.take_swept = 1'b0;
      cmd.owner      = req_ff.requester;
      cmd.stamp      = req_ff.now_us;
      w_other        = (wr_owner_ff != '0) && (wr_owner_ff != req_ff.requester);
      if (req_ff.requester != '0) begin
         case (rwl_op_type'(req_ff.req_type))
            OP_ACQ_SH: begin
               if (!(w_other && wvalid_ff)) begin
                  w_clear = w_other;
                  if (row.hit_any) begin
                     grant = 1'b1;
                  end else if (row.free_seen) begin
                     cmd.take_free = 1'b1;
                     inc           = 1'b1;
                     grant         = 1'b1;
                  end else if (row.cnt_exp != '0) begin
                     // full row: sweep, then reuse the lowest swept slot
                     cmd.sweep_exp  = 1'b1;
                     cmd.take_swept = 1'b1;
                     cleaned        = row.cnt_exp;
                     dec            = row.cnt_exp;
                     inc            = 1'b1;
                     grant          = 1'b1;
                  end
               end
            end
            OP_REL_SH: begin
               if (row.hit_any) begin
                  cmd.clear_hit = 1'b1;
                  dec           = CNT_W'(1);
                  grant         = 1'b1;
               end
            end
            OP_ACQ_EX: begin
               if (wr_owner_ff == req_ff.requester) begin
                  grant = 1'b1;
               end else if (!(w_other && wvalid_ff)) begin
                  w_clear = w_other;
                  if (total_ff != '0) begin
                     cmd.sweep_exp = 1'b1;
                     cleaned       = row.cnt_exp;
                     dec           = row.cnt_exp;
                  end
                  if (total_ff == row.cnt_exp || total_ff == '0) begin
                     w_take = 1'b1;
                     grant  = 1'b1;
                  end
               end
            end
            OP_REL_EX: begin
               if (wr_owner_ff == req_ff.requester) begin
                  w_clear = 1'b1;
                  grant   = 1'b1;
               end
            end
            OP_CLEAR_DEAD: begin
               cmd.sweep_dead = 1'b1;
               cleaned        = row.cnt_dead;
               dec            = row.cnt_dead;
               w_clear        = w_other && !wvalid_ff;
               grant          = 1'b1;
            end
            OP_SWEEP: begin
               cmd.sweep_exp = 1'b1;
               cleaned       = row.cnt_exp;
               dec           = row.cnt_exp;
               grant         = 1'b1;
            end
            default: begin
               grant = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      total_in    = total_ff;
      wr_owner_in = wr_owner_ff;
      wr_stamp_in = wr_stamp_ff;
      if (apply) begin
         total_in = total_ff - dec + CNT_W'(inc);
         if (w_take) begin
            wr_owner_in = req_ff.requester;
            wr_stamp_in = req_ff.now_us;
         end else if (w_clear) begin
            wr_owner_in = '0;
            wr_stamp_in = '0;
         end
      end
      rsp_valid_in       = apply;
      rsp_in.granted     = grant;
      rsp_in.cleaned     = rwl_sat(cleaned);
      rsp_in.readers_now = rwl_sat(total_in);
      rsp_in.writer_now  = wr_owner_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lease_ff     <= LEASE_RESET;
         wr_owner_ff  <= '0;
         wr_stamp_ff  <= '0;
         wvalid_ff    <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lease_ff     <= lease_in;
         wr_owner_ff  <= wr_owner_in;
         wr_stamp_ff  <= wr_stamp_in;
         wvalid_ff    <= wvalid_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### hdl/reader_writer_lock_slot_table.sv
// Reader-writer lock: writer register plus a row of reader slot cells.
// The request and slot flags are registered at accept; the apply cycle's result is registered onto rsp_valid/rsp_data.
// A new request is accepted only while idle (busy low); slot flags are sampled in the accept cycle and
// the row chain resolves and writes back in the single apply cycle (busy high).
// Reset (synchronous): all slots free, no writer, reader count 0, lease 5000000 us.
// Results are not flow-controlled: rsp_valid is high for exactly one cycle per request.
`default_nettype none
module reader_writer_lock_slot_table import rwl_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire rwl_req_type         req_data,
   output logic                     rsp_valid,
   output rwl_rsp_type              rsp_data,
   input  wire logic                csr_we,
   input  wire logic [LEASE_W-1:0]  csr_wdata
);

   rwl_probe_type probe;
   rwl_cmd_type   cmd;
   rwl_chain_type chain [READER_SLOTS+1];

   assign chain[0] = '0;

   for (genvar i = 0; i < READER_SLOTS; i++) begin : g_slot
      rwl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe     (probe),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   rwl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .probe     (probe),
      .cmd       (cmd),
      .row       (chain[READER_SLOTS])
   );

endmodule
`default_nettype wire

### hdl/rwl_checker.sv
// port-level checker for the reader-writer lock, bound to the top level
`default_nettype none
`include "reader_writer_lock_slot_table_assert.svh"
module rwl_checker import rwl_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire rwl_rsp_type rsp_data
);

   `RWL_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy)
   `RWL_ASSERT_NXT(a_busy_gives_beat, busy, rsp_valid && !busy)
   `RWL_ASSERT_IMP(a_beat_follows_busy, rsp_valid, $past(busy))
   `RWL_ASSERT_IMP(a_readers_bounded, rsp_valid, 32'(rsp_data.readers_now) <= READER_SLOTS)

endmodule

bind reader_writer_lock_slot_table rwl_checker u_rwl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
